@@ rtl/bba_pkg.sv @@
package bba_pkg;

	localparam int DEF_NUM_BLOCKS = 1024;
	localparam int DEF_MAX_ORDERS = 11;

	localparam int ADDR_W     = 22;
	localparam int LEN_W      = 22;
	localparam int GORD_W     = 4;
	localparam int STATUS_W   = 2;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int SHIFT_W    = 6;

	localparam logic [CFG_W-1:0] MAX_BS_LOG2 = 4'd12;
	localparam logic [CFG_W-1:0] RST_BS_LOG2 = 4'd4;
	localparam logic [CFG_W-1:0] RST_LEVELS  = 4'd11;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN_USE   = 1'd1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [LEN_W-1:0]  request_length;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   block_address;
		logic [GORD_W-1:0]   granted_order;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_CLR_END,
		CMD_LOAD,
		CMD_WANT,
		CMD_FIND,
		CMD_SCAN_RD,
		CMD_SCAN_CHK,
		CMD_TAKE,
		CMD_SPLIT,
		CMD_ALLOC_FIN,
		CMD_FREE_RD,
		CMD_FREE_CHK,
		CMD_MERGE_RD,
		CMD_MERGE_CHK,
		CMD_MERGE_SET,
		CMD_ERR_NO_MEM,
		CMD_ERR_BAD_FREE,
		CMD_EMIT
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic too_big;
		logic bad_addr;
		logic ord_found;
		logic rd_bit;
		logic alloc_bit;
		logic o_eq_want;
		logic o_m1_eq_want;
		logic o_ge_top;
		logic clr_last;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/bba_datapath.sv @@
module bba_datapath #(
	parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS,
	parameter int MAX_ORDERS = bba_pkg::DEF_MAX_ORDERS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bba_pkg::cmd_t                   cmd,
	input  bba_pkg::req_t                   req,
	input  logic                            cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            rsp_stall,
	output logic                            rsp_valid,
	output bba_pkg::rsp_t                   rsp,
	output bba_pkg::dp_status_t             status
);

	localparam int NODES  = 2 * NUM_BLOCKS;
	localparam int NODE_W = $clog2(NODES);
	localparam int BLK_W  = $clog2(NUM_BLOCKS);
	localparam int ORD_W  = $clog2(MAX_ORDERS);
	localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
	localparam logic [NODE_W-1:0] CLR_LAST = NODE_W'(NODES - 1);

	logic                 nf_mem [NODES];
	logic                 al_mem [NUM_BLOCKS];
	logic [ORD_W-1:0]     ord_mem [NUM_BLOCKS];

	logic [CNT_W-1:0]     cnt_q [MAX_ORDERS];
	logic [bba_pkg::CFG_W-1:0] bs_reg_q, lv_reg_q;
	logic [NODE_W-1:0]    clr_q;
	logic                 rsp_valid_q;
	bba_pkg::rsp_t        rsp_q;

	bba_pkg::req_t        req_q;
	logic [ORD_W-1:0]     want_q, o_q;
	logic [BLK_W-1:0]     blk_q;
	logic                 rd_q, al_rd_q;
	logic [ORD_W-1:0]     ord_rd_q;
	bba_pkg::rsp_t        res_q;

	logic [bba_pkg::CFG_W-1:0] bs_c, lv_c;
	logic [ORD_W-1:0]     top_c, want_c, find_c, o_m1_c, orig_c;
	logic                 want_ok_c, find_ok_c;
	logic [BLK_W-1:0]     bit_o_c, bit_m1_c, free_blk_c;
	logic [bba_pkg::ADDR_W-1:0] blk_addr_c, align_mask_c;
	logic                 out_free_c;

	function automatic logic [NODE_W-1:0] node_idx(input logic [ORD_W-1:0] o,
			input logic [BLK_W-1:0] b);
		logic [NODE_W-1:0] base;
		logic [BLK_W-1:0]  sh;
		base = NODE_W'(1) << (ORD_W'(MAX_ORDERS - 1) - o);
		sh   = b >> o;
		return base + NODE_W'(sh);
	endfunction

	// effective register values
	always_comb begin
		bs_c = (bs_reg_q > bba_pkg::MAX_BS_LOG2) ? bba_pkg::MAX_BS_LOG2 : bs_reg_q;
		if (lv_reg_q == '0) begin
			lv_c = bba_pkg::CFG_W'(1);
		end else if (lv_reg_q > bba_pkg::CFG_W'(MAX_ORDERS)) begin
			lv_c = bba_pkg::CFG_W'(MAX_ORDERS);
		end else begin
			lv_c = lv_reg_q;
		end
		top_c = ORD_W'(lv_c - bba_pkg::CFG_W'(1));
	end

	// smallest order whose block holds the length
	always_comb begin
		logic [bba_pkg::SHIFT_W-1:0] sh;
		logic fit;
		want_c    = '0;
		want_ok_c = 1'b0;
		for (int o = 0; o < MAX_ORDERS; o++) begin
			sh  = bba_pkg::SHIFT_W'(bs_c) + bba_pkg::SHIFT_W'(o);
			fit = (sh >= bba_pkg::SHIFT_W'(bba_pkg::LEN_W)) ||
				((bba_pkg::LEN_W+1)'(req_q.request_length) <=
				((bba_pkg::LEN_W+1)'(1) << sh));
			if (!want_ok_c && ORD_W'(o) <= top_c && fit) begin
				want_ok_c = 1'b1;
				want_c    = ORD_W'(o);
			end
		end
	end

	// smallest order at or above the wanted one holding a free node
	always_comb begin
		find_c    = '0;
		find_ok_c = 1'b0;
		for (int o = 0; o < MAX_ORDERS; o++) begin
			if (!find_ok_c && ORD_W'(o) >= want_q && ORD_W'(o) <= top_c &&
					cnt_q[o] != '0) begin
				find_ok_c = 1'b1;
				find_c    = ORD_W'(o);
			end
		end
	end

	always_comb begin
		o_m1_c       = o_q - ORD_W'(1);
		bit_o_c      = BLK_W'(1) << o_q;
		bit_m1_c     = BLK_W'(1) << o_m1_c;
		orig_c       = (ord_rd_q > top_c) ? top_c : ord_rd_q;
		align_mask_c = ~({bba_pkg::ADDR_W{1'b1}} << bs_c);
		free_blk_c   = BLK_W'(req_q.address >> bs_c);
		blk_addr_c   = bba_pkg::ADDR_W'(bba_pkg::ADDR_W'(blk_q) << bs_c);
		out_free_c   = !rsp_valid_q || !rsp_stall;
	end

	always_comb begin
		status.mode         = req_q.mode;
		status.too_big      = !want_ok_c;
		status.bad_addr     = ((req_q.address & align_mask_c) != '0) ||
			(((req_q.address >> bs_c) >> top_c) != '0);
		status.ord_found    = find_ok_c;
		status.rd_bit       = rd_q;
		status.alloc_bit    = al_rd_q;
		status.o_eq_want    = (o_q == want_q);
		status.o_m1_eq_want = (o_m1_c == want_q);
		status.o_ge_top     = (o_q >= top_c);
		status.clr_last     = (clr_q == CLR_LAST);
		status.out_free     = out_free_c;
	end

	// control state: registers, free counts, clear pointer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_reg_q    <= bba_pkg::RST_BS_LOG2;
			lv_reg_q    <= bba_pkg::RST_LEVELS;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int o = 0; o < MAX_ORDERS; o++) begin
				cnt_q[o] <= '0;
			end
		end else begin
			if (!cfg_we && cmd == bba_pkg::CMD_EMIT && out_free_c) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				clr_q <= '0;
				if (cfg_index == bba_pkg::CFG_BLOCK_SIZE_LOG2) begin
					bs_reg_q <= cfg_data;
				end else begin
					lv_reg_q <= cfg_data;
				end
			end else begin
				unique case (cmd)
					bba_pkg::CMD_CLEAR: begin
						clr_q <= clr_q + NODE_W'(1);
					end
					bba_pkg::CMD_CLR_END: begin
						clr_q <= '0;
						for (int o = 0; o < MAX_ORDERS; o++) begin
							cnt_q[o] <= (ORD_W'(o) == top_c) ? CNT_W'(1) : '0;
						end
					end
					bba_pkg::CMD_TAKE, bba_pkg::CMD_MERGE_CHK: begin
						cnt_q[o_q] <= cnt_q[o_q] - CNT_W'(1);
					end
					bba_pkg::CMD_SPLIT: begin
						cnt_q[o_m1_c] <= cnt_q[o_m1_c] + CNT_W'(1);
					end
					bba_pkg::CMD_MERGE_SET: begin
						cnt_q[o_q] <= cnt_q[o_q] + CNT_W'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload and memories
	always_ff @(posedge clk) begin
		unique case (cmd)
			bba_pkg::CMD_CLEAR: begin
				nf_mem[clr_q]              <= 1'b0;
				al_mem[clr_q[BLK_W-1:0]]   <= 1'b0;
			end
			bba_pkg::CMD_CLR_END: begin
				nf_mem[node_idx(top_c, '0)] <= 1'b1;
			end
			bba_pkg::CMD_LOAD: begin
				req_q <= req;
			end
			bba_pkg::CMD_WANT: begin
				want_q <= want_c;
			end
			bba_pkg::CMD_FIND: begin
				o_q   <= find_c;
				blk_q <= '0;
			end
			bba_pkg::CMD_SCAN_RD: begin
				rd_q <= nf_mem[node_idx(o_q, blk_q)];
			end
			bba_pkg::CMD_SCAN_CHK: begin
				if (!rd_q) begin
					blk_q <= blk_q + bit_o_c;
				end
			end
			bba_pkg::CMD_TAKE: begin
				nf_mem[node_idx(o_q, blk_q)] <= 1'b0;
			end
			bba_pkg::CMD_SPLIT: begin
				nf_mem[node_idx(o_m1_c, blk_q | bit_m1_c)] <= 1'b1;
				o_q <= o_m1_c;
			end
			bba_pkg::CMD_ALLOC_FIN: begin
				al_mem[blk_q]  <= 1'b1;
				ord_mem[blk_q] <= want_q;
				res_q.block_address <= blk_addr_c;
				res_q.granted_order <= bba_pkg::GORD_W'(want_q);
				res_q.status        <= bba_pkg::ST_OK;
			end
			bba_pkg::CMD_FREE_RD: begin
				blk_q    <= free_blk_c;
				al_rd_q  <= al_mem[free_blk_c];
				ord_rd_q <= ord_mem[free_blk_c];
			end
			bba_pkg::CMD_FREE_CHK: begin
				al_mem[blk_q] <= 1'b0;
				o_q <= orig_c;
				res_q.block_address <= '0;
				res_q.granted_order <= bba_pkg::GORD_W'(orig_c);
				res_q.status        <= bba_pkg::ST_OK;
			end
			bba_pkg::CMD_MERGE_RD: begin
				rd_q <= nf_mem[node_idx(o_q, blk_q ^ bit_o_c)];
			end
			bba_pkg::CMD_MERGE_CHK: begin
				nf_mem[node_idx(o_q, blk_q ^ bit_o_c)] <= 1'b0;
				blk_q <= blk_q & ~bit_o_c;
				o_q   <= o_q + ORD_W'(1);
			end
			bba_pkg::CMD_MERGE_SET: begin
				nf_mem[node_idx(o_q, blk_q)] <= 1'b1;
			end
			bba_pkg::CMD_ERR_NO_MEM: begin
				res_q.block_address <= '0;
				res_q.granted_order <= '0;
				res_q.status        <= bba_pkg::ST_NO_MEM;
			end
			bba_pkg::CMD_ERR_BAD_FREE: begin
				res_q.block_address <= '0;
				res_q.granted_order <= '0;
				res_q.status        <= bba_pkg::ST_BAD_FREE;
			end
			bba_pkg::CMD_EMIT: begin
				if (out_free_c) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/bba_ctrl.sv @@
module bba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                cfg_we,
	input  bba_pkg::dp_status_t status,
	output bba_pkg::cmd_t       cmd,
	output logic                busy
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_CLR_END,
		S_IDLE,
		S_CALC,
		S_FIND,
		S_SCAN,
		S_SCAN_CHK,
		S_TAKE,
		S_SPLIT,
		S_ALLOC_FIN,
		S_FREE_CHK,
		S_MERGE,
		S_MERGE_CHK,
		S_MERGE_SET,
		S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		cmd     = bba_pkg::CMD_NONE;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd = bba_pkg::CMD_CLEAR;
				if (status.clr_last) begin
					state_d = S_CLR_END;
				end
			end
			S_CLR_END: begin
				cmd     = bba_pkg::CMD_CLR_END;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd     = bba_pkg::CMD_LOAD;
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				if (status.mode == bba_pkg::MODE_ALLOC) begin
					if (status.too_big) begin
						cmd     = bba_pkg::CMD_ERR_NO_MEM;
						state_d = S_EMIT;
					end else begin
						cmd     = bba_pkg::CMD_WANT;
						state_d = S_FIND;
					end
				end else if (status.bad_addr) begin
					cmd     = bba_pkg::CMD_ERR_BAD_FREE;
					state_d = S_EMIT;
				end else begin
					cmd     = bba_pkg::CMD_FREE_RD;
					state_d = S_FREE_CHK;
				end
			end
			S_FIND: begin
				if (status.ord_found) begin
					cmd     = bba_pkg::CMD_FIND;
					state_d = S_SCAN;
				end else begin
					cmd     = bba_pkg::CMD_ERR_NO_MEM;
					state_d = S_EMIT;
				end
			end
			S_SCAN: begin
				cmd     = bba_pkg::CMD_SCAN_RD;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				cmd     = bba_pkg::CMD_SCAN_CHK;
				state_d = status.rd_bit ? S_TAKE : S_SCAN;
			end
			S_TAKE: begin
				cmd     = bba_pkg::CMD_TAKE;
				state_d = status.o_eq_want ? S_ALLOC_FIN : S_SPLIT;
			end
			S_SPLIT: begin
				cmd = bba_pkg::CMD_SPLIT;
				if (status.o_m1_eq_want) begin
					state_d = S_ALLOC_FIN;
				end
			end
			S_ALLOC_FIN: begin
				cmd     = bba_pkg::CMD_ALLOC_FIN;
				state_d = S_EMIT;
			end
			S_FREE_CHK: begin
				if (status.alloc_bit) begin
					cmd     = bba_pkg::CMD_FREE_CHK;
					state_d = S_MERGE;
				end else begin
					cmd     = bba_pkg::CMD_ERR_BAD_FREE;
					state_d = S_EMIT;
				end
			end
			S_MERGE: begin
				if (status.o_ge_top) begin
					state_d = S_MERGE_SET;
				end else begin
					cmd     = bba_pkg::CMD_MERGE_RD;
					state_d = S_MERGE_CHK;
				end
			end
			S_MERGE_CHK: begin
				if (status.rd_bit) begin
					cmd     = bba_pkg::CMD_MERGE_CHK;
					state_d = S_MERGE;
				end else begin
					state_d = S_MERGE_SET;
				end
			end
			S_MERGE_SET: begin
				cmd     = bba_pkg::CMD_MERGE_SET;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd = bba_pkg::CMD_EMIT;
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		// a register write re-initialises the pool
		if (cfg_we) begin
			cmd     = bba_pkg::CMD_NONE;
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

@@ rtl/buddy_block_allocator.sv @@
// binary buddy allocator over a pool of power-of-two basic blocks
// req channel (req_valid/req_stall, req): mode 0 allocates request_length
// bytes, mode 1 frees the block starting at address. a transaction is
// taken when req_valid is high and req_stall low
// rsp channel (rsp_valid/rsp_stall, rsp): exactly one result per request,
// block offset, order and status, held in an output register
// cfg channel (cfg_valid/cfg_ready): index 0 block_size_log2, index 1
// levels_in_use; any write re-initialises the pool
// allocate time grows with the blocks scanned at the chosen order and
// the orders split, free time with the orders merged, and merging that
// stops below the top order also passes S_MERGE_CHK; the single-port
// free-bit memory and the one-node-per-read scan set this
// one request is worked on at a time; req_stall stays high until its
// result is in the output register, and falls in the same cycle that
// rsp_valid rises
// after reset or a register write the free-bit memory, all
// 2 * NUM_BLOCKS nodes, is cleared with req_stall high
// when rsp_stall is high the result waits and the next request is
// only taken once the output register has room for its result
module buddy_block_allocator #(
	parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS,
	parameter int MAX_ORDERS = bba_pkg::DEF_MAX_ORDERS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bba_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bba_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::CFG_W-1:0]     cfg_data
);

	bba_pkg::cmd_t       cmd;
	bba_pkg::dp_status_t status;
	logic                busy;
	logic                cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign req_stall = busy;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.cfg_we   (cfg_we),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	bba_datapath #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.MAX_ORDERS(MAX_ORDERS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.status   (status)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !cfg_valid |=> req_stall)
		else $error("request taken while previous one still in flight");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bba_pkg::ST_OK |->
		rsp.block_address == '0 && rsp.granted_order == '0)
		else $error("error result carries address or order");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without a request being worked on");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	bba_pkg::req_t                 req;
	logic                          rsp_valid;
	logic                          rsp_stall;
	bba_pkg::rsp_t                 rsp;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [bba_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bba_pkg::CFG_W-1:0]     cfg_data;

	buddy_block_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// allocator mirror
	logic [bba_pkg::CFG_W-1:0]  size_log2_reg;
	logic [bba_pkg::CFG_W-1:0]  levels_reg;
	bit                         tree_free [2*bba_pkg::DEF_NUM_BLOCKS];
	bit                         block_taken [bba_pkg::DEF_NUM_BLOCKS];
	logic [bba_pkg::GORD_W-1:0] taken_order [bba_pkg::DEF_NUM_BLOCKS];
	logic [bba_pkg::ADDR_W-1:0] live_blocks [$];

	bba_pkg::req_t pending_reqs [$];
	bba_pkg::rsp_t expected_rsps [$];
	int   error_count;
	int   req_gap;
	int   stall_left;
	int   squeeze_req;
	int   squeeze_seen;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned levels_eff();
		if (levels_reg < 1) return 1;
		if (levels_reg > bba_pkg::DEF_MAX_ORDERS) return bba_pkg::DEF_MAX_ORDERS;
		return levels_reg;
	endfunction

	function automatic int unsigned size_log2_eff();
		return (size_log2_reg > bba_pkg::MAX_BS_LOG2) ? bba_pkg::MAX_BS_LOG2 : size_log2_reg;
	endfunction

	function automatic int unsigned tree_node(int unsigned ord, int unsigned blk);
		return ((1 << (bba_pkg::DEF_MAX_ORDERS - 1 - ord)) + (blk >> ord)) %
			(2 * bba_pkg::DEF_NUM_BLOCKS);
	endfunction

	function automatic void pool_reset();
		foreach (tree_free[i]) tree_free[i] = 1'b0;
		foreach (block_taken[i]) block_taken[i] = 1'b0;
		live_blocks.delete();
		tree_free[tree_node(levels_eff() - 1, 0)] = 1'b1;
	endfunction

	function automatic void drop_live(logic [bba_pkg::ADDR_W-1:0] a);
		foreach (live_blocks[i])
			if (live_blocks[i] == a) begin
				live_blocks.delete(i);
				return;
			end
	endfunction

	function automatic bba_pkg::rsp_t buddy_predict(bba_pkg::req_t r);
		bba_pkg::rsp_t o;
		int unsigned   top;
		int unsigned   bs;
		int unsigned   pool;
		int unsigned   want;
		int unsigned   ord;
		int unsigned   blk;
		int unsigned   orig;
		int unsigned   bud;
		bit            found;
		logic [63:0]   len;
		logic [63:0]   addr;
		o = '0;
		top = levels_eff() - 1;
		bs = size_log2_eff();
		pool = 1 << top;
		if (r.mode == bba_pkg::MODE_ALLOC) begin
			len = r.request_length;
			want = 0;
			o.status = bba_pkg::ST_OK;
			while ((64'd1 << (bs + want)) < len) begin
				if (want >= top) begin
					o.status = bba_pkg::ST_NO_MEM;
					break;
				end
				want++;
			end
			if (o.status != bba_pkg::ST_OK) return o;
			found = 1'b0;
			ord = want;
			blk = 0;
			while (!found && ord <= top) begin
				blk = 0;
				while (!found && blk < pool) begin
					if (tree_free[tree_node(ord, blk)]) found = 1'b1;
					else blk += (1 << ord);
				end
				if (!found) ord++;
			end
			if (!found) begin
				o.status = bba_pkg::ST_NO_MEM;
				return o;
			end
			tree_free[tree_node(ord, blk)] = 1'b0;
			// split down, upper halves stay free
			while (ord > want) begin
				ord--;
				tree_free[tree_node(ord, blk + (1 << ord))] = 1'b1;
			end
			block_taken[blk] = 1'b1;
			taken_order[blk] = want;
			o.block_address = blk << bs;
			o.granted_order = want;
			live_blocks.push_back(o.block_address);
		end else begin
			addr = r.address;
			if ((addr & ((64'd1 << bs) - 1)) != 0 || (addr >> bs) >= pool) begin
				o.status = bba_pkg::ST_BAD_FREE;
				return o;
			end
			blk = addr >> bs;
			if (!block_taken[blk]) begin
				o.status = bba_pkg::ST_BAD_FREE;
				return o;
			end
			block_taken[blk] = 1'b0;
			drop_live(r.address);
			orig = taken_order[blk];
			if (orig > top) orig = top;
			ord = orig;
			while (ord < top) begin
				bud = tree_node(ord, blk ^ (1 << ord));
				if (!tree_free[bud]) break;
				tree_free[bud] = 1'b0;
				blk &= ~(1 << ord);
				ord++;
			end
			tree_free[tree_node(ord, blk)] = 1'b1;
			o.granted_order = orig;
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// sender: one transaction offered at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			req_gap   <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(buddy_predict(req));
				void'(pending_reqs.pop_front());
				if ($urandom_range(0, 99) < 40) req_gap <= pick_gap();
				req_valid <= 1'b0;
			end else if (!req_valid) begin
				if (req_gap > 0) begin
					req_gap <= req_gap - 1;
				end else if (pending_reqs.size() > 0) begin
					req_valid <= 1'b1;
					req       <= pending_reqs[0];
				end
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall    <= 1'b0;
			stall_left   <= 0;
			squeeze_seen <= 0;
		end else if (squeeze_seen != squeeze_req) begin
			squeeze_seen <= squeeze_req;
			stall_left   <= 600;
			rsp_stall    <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else if ($urandom_range(0, 99) < 75) begin
			rsp_stall <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			rsp_stall  <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin
		bba_pkg::rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected transaction", rsp, 0);
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rsp.block_address !== exp_rsp.block_address)
					report_mismatch("block_address", rsp.block_address,
						exp_rsp.block_address);
				if (rsp.granted_order !== exp_rsp.granted_order)
					report_mismatch("granted_order", rsp.granted_order,
						exp_rsp.granted_order);
				if (rsp.status !== exp_rsp.status)
					report_mismatch("status", rsp.status, exp_rsp.status);
			end
		end
	end

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic reg_write(input logic [bba_pkg::CFG_IDX_W-1:0] idx,
			input logic [bba_pkg::CFG_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == bba_pkg::CFG_BLOCK_SIZE_LOG2) size_log2_reg = d;
		else levels_reg = d;
		pool_reset();
	endtask

	task automatic offer(input bba_pkg::req_t r);
		while (pending_reqs.size() >= 2) @(posedge clk);
		pending_reqs.push_back(r);
	endtask

	task automatic offer_op(input logic m, input int unsigned len, input int unsigned a);
		bba_pkg::req_t r;
		r.mode = m;
		r.request_length = len;
		r.address = a;
		offer(r);
	endtask

	function automatic bba_pkg::req_t random_req();
		bba_pkg::req_t r;
		int unsigned k;
		int unsigned top;
		int unsigned bs;
		int unsigned w;
		longint      sz;
		top = levels_eff() - 1;
		bs = size_log2_eff();
		r.mode = bba_pkg::MODE_ALLOC;
		r.request_length = $urandom;
		r.address = $urandom;
		k = $urandom_range(0, 99);
		if (k < 45 && live_blocks.size() > 0) begin
			r.mode = bba_pkg::MODE_FREE;
			r.address = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
		end else if (k < 49) begin
			r.mode = bba_pkg::MODE_FREE;
		end else if (k < 53) begin
			// aligned and inside the pool, often not a live block start
			r.mode = bba_pkg::MODE_FREE;
			r.address = $urandom_range(0, (1 << top) - 1) << bs;
		end else if (k < 58) begin
			r.request_length = $urandom;
		end else if (k < 61) begin
			r.request_length = 0;
		end else begin
			w = $urandom_range(0, $urandom_range(0, top));
			sz = longint'(1) << (bs + w);
			sz = sz - $urandom_range(0, sz / 2);
			if (sz > 4194303) sz = 4194303;
			r.request_length = sz;
		end
		return r;
	endfunction

	initial begin
		int unsigned phase_bs [8];
		int unsigned phase_lv [8];
		phase_bs      = '{0, 15, 12, 2, 7, 4, 3, 9};
		phase_lv      = '{3, 5, 1, 0, 15, 6, 4, 11};
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		error_count   = 0;
		squeeze_req   = 0;
		size_log2_reg = bba_pkg::RST_BS_LOG2;
		levels_reg    = bba_pkg::RST_LEVELS;
		pool_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part on the reset setting
		offer_op(bba_pkg::MODE_ALLOC, 0, 22'h3fffff);
		offer_op(bba_pkg::MODE_ALLOC, 1, 0);
		offer_op(bba_pkg::MODE_ALLOC, 16, 0);
		offer_op(bba_pkg::MODE_ALLOC, 17, 0);
		offer_op(bba_pkg::MODE_ALLOC, 22'h3fffff, 0);
		offer_op(bba_pkg::MODE_ALLOC, 16385, 0);
		offer_op(bba_pkg::MODE_FREE, 0, 3);
		offer_op(bba_pkg::MODE_FREE, 0, 20000);
		offer_op(bba_pkg::MODE_FREE, 0, 22'h3fffff);
		offer_op(bba_pkg::MODE_FREE, 0, 128);
		offer_op(bba_pkg::MODE_FREE, 0, 0);
		offer_op(bba_pkg::MODE_FREE, 22'h3fffff, 0);
		offer_op(bba_pkg::MODE_FREE, 0, 16);
		offer_op(bba_pkg::MODE_FREE, 0, 32);
		offer_op(bba_pkg::MODE_FREE, 0, 64);
		offer_op(bba_pkg::MODE_ALLOC, 16384, 0);
		offer_op(bba_pkg::MODE_ALLOC, 1, 0);
		offer_op(bba_pkg::MODE_FREE, 0, 0);
		offer_op(bba_pkg::MODE_ALLOC, 8192, 0);
		offer_op(bba_pkg::MODE_ALLOC, 8193, 0);
		offer_op(bba_pkg::MODE_FREE, 0, 8192);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			reg_write(bba_pkg::CFG_BLOCK_SIZE_LOG2, phase_bs[p]);
			reg_write(bba_pkg::CFG_LEVELS_IN_USE, phase_lv[p]);
			if (p == 1) squeeze_req++;
			for (int i = 0; i < 100; i++) offer(random_req());
			wait_idle();
		end

		if (error_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
rtl/bba_pkg.sv
rtl/bba_datapath.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator.sv
verif/tb_top.sv
